// File: hw/rtl/cvt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the camera view transform block.
// Used by the controller, the datapath, the top level and the checker.
package cvt_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TAB_LEN      = 24;
    localparam int STEP_W       = 5;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

    localparam int COORD_W = 32;
    localparam int ME_W    = 18;   // matrix entry, Q2.16
    localparam int T_W     = 19;   // rotation entry with headroom for negation
    localparam int D_W     = 33;   // point minus camera
    localparam int P_W     = ME_W + D_W;
    localparam int ACC_W   = P_W + 3;
    localparam int CX_W    = 34;   // CORDIC x, y in Q4.30
    localparam int CZ_W    = 33;   // CORDIC residual angle

    typedef enum logic [2:0] {
        CMD_XFORM = 3'd0,
        CMD_ROT_X = 3'd1,
        CMD_ROT_Y = 3'd2,
        CMD_ROT_Z = 3'd3,
        CMD_LOAD  = 3'd4
    } cmd_t;

    localparam logic [1:0] REG_CAM_X = 2'd0;
    localparam logic [1:0] REG_CAM_Y = 2'd1;
    localparam logic [1:0] REG_CAM_Z = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic              capture;
        logic              cordic_step;
        logic              sc_load;
        logic              mul;
        logic              acc;
        logic              wr;
        logic              commit;
        logic              out_load;
        logic [STEP_W-1:0] step;
        logic [1:0]        r;
        logic [1:0]        c;
        logic [1:0]        k;
    } cvt_ctl_t;

    function automatic logic [29:0] atan_val(input logic [STEP_W-1:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/cvt_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the camera view transform: CORDIC steps, multiply-accumulate
// passes and output handoff. Depends on cvt_pkg.
module cvt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [2:0]      cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output cvt_pkg::cvt_ctl_t ctl
);
    import cvt_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CORD   = 8'b0000_0010,
        S_SC     = 8'b0000_0100,
        S_MUL    = 8'b0000_1000,
        S_ACC    = 8'b0001_0000,
        S_WR     = 8'b0010_0000,
        S_COMMIT = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        r_reg, r_next, c_reg, c_next, k_reg, k_next;
    logic              xform_reg, xform_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        k_next     = k_reg;
        xform_next = xform_reg;
        in_ready   = 1'b0;
        ctl        = '0;
        ctl.step   = step_reg;
        ctl.r      = r_reg;
        ctl.c      = c_reg;
        ctl.k      = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    r_next = 2'd0;
                    c_next = 2'd0;
                    k_next = 2'd0;
                    step_next = '0;
                    case (cmd)
                        CMD_XFORM:
                        begin
                            xform_next = 1'b1;
                            state_next = S_MUL;
                        end
                        CMD_ROT_X, CMD_ROT_Y, CMD_ROT_Z:
                        begin
                            xform_next = 1'b0;
                            state_next = S_CORD;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_CORD:
            begin
                ctl.cordic_step = 1'b1;
                if (step_reg == STEP_LAST)
                    state_next = S_SC;
                else
                    step_next = step_reg + 1'b1;
            end
            S_SC:
            begin
                ctl.sc_load = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                ctl.mul = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                ctl.acc = 1'b1;
                if (k_reg == 2'd2)
                    state_next = S_WR;
                else
                begin
                    k_next = k_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_WR:
            begin
                ctl.wr = 1'b1;
                k_next = 2'd0;
                state_next = S_MUL;
                if (xform_reg)
                begin
                    if (r_reg == 2'd2)
                        state_next = S_DONE;
                    else
                        r_next = r_reg + 1'b1;
                end
                else if (c_reg == 2'd2)
                begin
                    c_next = 2'd0;
                    if (r_reg == 2'd2)
                        state_next = S_COMMIT;
                    else
                        r_next = r_reg + 1'b1;
                end
                else
                    c_next = c_reg + 1'b1;
            end
            S_COMMIT:
            begin
                ctl.commit = 1'b1;
                state_next = S_IDLE;
            end
            S_DONE:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    ctl.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid_next = ctl.out_load | (out_valid_reg & ~out_ready);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            r_reg         <= 2'd0;
            c_reg         <= 2'd0;
            k_reg         <= 2'd0;
            xform_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            k_reg         <= k_next;
            xform_reg     <= xform_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hw/rtl/cvt_dp.sv
`timescale 1ns / 1ps
// Datapath: camera position, view matrix, CORDIC sine/cosine and one shared
// multiply-accumulate unit. Depends on cvt_pkg; driven by cvt_ctrl.
module cvt_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cvt_pkg::cvt_ctl_t          ctl,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_addr,
    input  logic [31:0]                cfg_wdata,
    input  logic [2:0]                 cmd,
    input  logic signed [31:0]         coord_x,
    input  logic signed [31:0]         coord_y,
    input  logic signed [31:0]         coord_z,
    input  logic [15:0]                angle,
    input  logic [1:0]                 row_sel,
    output logic signed [31:0]         view_x,
    output logic signed [31:0]         view_y,
    output logic signed [31:0]         view_z
);
    import cvt_pkg::*;

    localparam logic signed [T_W-1:0] ONE_T = T_W'(65536);

    function automatic logic signed [ME_W-1:0] sat18_acc(input logic signed [ACC_W-1:0] v);
        logic signed [ME_W-1:0] o;
        if (v > ACC_W'(131071))
            o = ME_W'(131071);
        else if (v < -ACC_W'(131072))
            o = -ME_W'(131072);
        else
            o = v[ME_W-1:0];
        return o;
    endfunction

    function automatic logic signed [31:0] sat32_acc(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] o;
        if (v > ACC_W'(64'sd2147483647))
            o = 32'sh7FFF_FFFF;
        else if (v < -ACC_W'(64'sd2147483648))
            o = 32'sh8000_0000;
        else
            o = v[31:0];
        return o;
    endfunction

    function automatic logic signed [ME_W-1:0] sat18_in(input logic signed [31:0] v);
        logic signed [ME_W-1:0] o;
        if (v > 32'sd131071)
            o = ME_W'(131071);
        else if (v < -32'sd131072)
            o = -ME_W'(131072);
        else
            o = v[ME_W-1:0];
        return o;
    endfunction

    function automatic logic signed [T_W-1:0] q30_to_q16(input logic signed [CX_W-1:0] v);
        logic signed [CX_W-1:0] sh;
        logic signed [T_W-1:0]  o;
        sh = (v + CX_W'(8192)) >>> 14;
        if (sh > CX_W'(131071))
            o = T_W'(131071);
        else if (sh < -CX_W'(131072))
            o = -T_W'(131072);
        else
            o = T_W'(sh[ME_W-1:0]) | {{(T_W-ME_W){sh[ME_W-1]}}, {ME_W{1'b0}}};
        return o;
    endfunction

    function automatic logic signed [T_W-1:0] t_entry(input logic [2:0] op,
        input logic [1:0] k, input logic [1:0] c,
        input logic signed [T_W-1:0] cs, input logic signed [T_W-1:0] sn);
        logic signed [T_W-1:0] t;
        t = '0;
        case (op)
            CMD_ROT_X:
                case ({k, c})
                    4'b00_00: t = ONE_T;
                    4'b01_01: t = cs;
                    4'b01_10: t = -sn;
                    4'b10_01: t = sn;
                    4'b10_10: t = cs;
                    default:  t = '0;
                endcase
            CMD_ROT_Y:
                case ({k, c})
                    4'b00_00: t = cs;
                    4'b00_10: t = sn;
                    4'b01_01: t = ONE_T;
                    4'b10_00: t = -sn;
                    4'b10_10: t = cs;
                    default:  t = '0;
                endcase
            default:
                case ({k, c})
                    4'b00_00: t = cs;
                    4'b00_01: t = -sn;
                    4'b01_00: t = sn;
                    4'b01_01: t = cs;
                    4'b10_10: t = ONE_T;
                    default:  t = '0;
                endcase
        endcase
        return t;
    endfunction

    logic signed [31:0]     cam_reg [3];
    logic signed [ME_W-1:0] m_reg [9];
    logic signed [ME_W-1:0] nm_reg [9];
    logic signed [D_W-1:0]  d_reg [3];
    logic signed [31:0]     res_reg [3];
    logic signed [31:0]     out_reg [3];
    logic [2:0]             op_reg;
    logic [1:0]             q_reg;
    logic signed [CX_W-1:0] x_reg, y_reg;
    logic signed [CZ_W-1:0] z_reg;
    logic signed [T_W-1:0]  cs_reg, sn_reg;
    logic signed [P_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic signed [CX_W-1:0] dx, dy;
    logic signed [CZ_W-1:0] at;
    logic signed [T_W-1:0]  c_raw, s_raw, cs_next, sn_next;
    logic [3:0]             m_idx;
    logic [3:0]             row_base;
    logic signed [ME_W-1:0] mul_a;
    logic signed [D_W-1:0]  mul_b;
    logic signed [ACC_W-1:0] rnd;
    logic signed [ME_W-1:0] row_e [3];

    assign dx    = y_reg >>> ctl.step;
    assign dy    = x_reg >>> ctl.step;
    assign at    = CZ_W'(atan_val(ctl.step));
    assign c_raw = q30_to_q16(x_reg);
    assign s_raw = q30_to_q16(y_reg);

    always_comb
    begin
        case (q_reg)
            2'd0:    begin cs_next = c_raw;  sn_next = s_raw;  end
            2'd1:    begin cs_next = -s_raw; sn_next = c_raw;  end
            2'd2:    begin cs_next = -c_raw; sn_next = -s_raw; end
            default: begin cs_next = s_raw;  sn_next = -c_raw; end
        endcase
    end

    assign m_idx = ({2'b00, ctl.r} << 1) + {2'b00, ctl.r} + {2'b00, ctl.k};
    assign mul_a = m_reg[m_idx];
    assign mul_b = (op_reg == CMD_XFORM) ? d_reg[ctl.k]
                 : D_W'(t_entry(op_reg, ctl.k, ctl.c, cs_reg, sn_reg));
    assign rnd   = (acc_reg + ACC_W'(32768)) >>> 16;

    assign row_base = ({2'b00, row_sel} << 1) + {2'b00, row_sel};

    assign row_e[0] = sat18_in(coord_x);
    assign row_e[1] = sat18_in(coord_y);
    assign row_e[2] = sat18_in(coord_z);

    // camera position and view matrix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                cam_reg[i] <= '0;
            for (int i = 0; i < 9; i++)
                m_reg[i] <= (i % 4 == 0) ? ME_W'(65536) : '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_CAM_X: cam_reg[0] <= cfg_wdata;
                    REG_CAM_Y: cam_reg[1] <= cfg_wdata;
                    REG_CAM_Z: cam_reg[2] <= cfg_wdata;
                    default:   ;
                endcase
            end
            if (ctl.capture && cmd == CMD_LOAD && row_sel != 2'd3)
            begin
                for (int j = 0; j < 3; j++)
                    m_reg[row_base + 4'(j)] <= row_e[j];
            end
            if (ctl.commit)
            begin
                for (int i = 0; i < 9; i++)
                    m_reg[i] <= nm_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            op_reg   <= cmd;
            d_reg[0] <= D_W'(coord_x) - D_W'(cam_reg[0]);
            d_reg[1] <= D_W'(coord_y) - D_W'(cam_reg[1]);
            d_reg[2] <= D_W'(coord_z) - D_W'(cam_reg[2]);
            q_reg    <= angle[15:14];
            x_reg    <= CX_W'(652032875);
            y_reg    <= '0;
            z_reg    <= {3'b000, angle[13:0], 16'h0000};
        end
        if (ctl.cordic_step)
        begin
            if (!z_reg[CZ_W-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
        if (ctl.sc_load)
        begin
            cs_reg <= cs_next;
            sn_reg <= sn_next;
        end
        if (ctl.mul)
            prod_reg <= mul_a * mul_b;
        if (ctl.acc)
            acc_reg <= ((ctl.k == 2'd0) ? '0 : acc_reg) + ACC_W'(prod_reg);
        if (ctl.wr)
        begin
            if (op_reg == CMD_XFORM)
                res_reg[ctl.r] <= sat32_acc(rnd);
            else
                nm_reg[({2'b00, ctl.r} << 1) + {2'b00, ctl.r} + {2'b00, ctl.c}]
                    <= sat18_acc(rnd);
        end
        if (ctl.out_load)
        begin
            for (int i = 0; i < 3; i++)
                out_reg[i] <= res_reg[i];
        end
    end

    assign view_x = out_reg[0];
    assign view_y = out_reg[1];
    assign view_z = out_reg[2];

endmodule

// File: hw/rtl/camera_view_transform.sv
`timescale 1ns / 1ps
// Top level of the camera view transform block.
// Depends on cvt_pkg, cvt_ctrl and cvt_dp.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command item: transform,
//   rotate about x, y or z, or load one matrix row. Only a transform gives a
//   result item, on the output channel (out_valid/out_ready).
//   Camera position is written through cfg_wr_en/cfg_addr/cfg_wdata while
//   the block is idle; addresses other than 0..2 are dropped.
//   One item is worked on at a time; in_ready is high only while idle.
//   Transform: multiply-accumulate passes (9 products on one shared
//     multiplier, plus one write per row), then handoff to the output register.
//   Rotation: CORDIC_STEPS CORDIC steps, a sine/cosine load, then the 27 matrix
//     products on the same multiplier and a commit of the new matrix.
//   Load row and unused commands finish in the accept cycle.
//   A result sits in an output register; a new item is accepted while it
//   waits, and a following transform holds in its last step until the
//   receiver takes the waiting result.
//   Reset clears the camera position and sets the matrix to the identity.
module camera_view_transform (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_addr,
    input  logic [31:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          cmd,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_y,
    input  logic signed [31:0]  coord_z,
    input  logic [15:0]         angle,
    input  logic [1:0]          row_sel,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  view_x,
    output logic signed [31:0]  view_y,
    output logic signed [31:0]  view_z
);
    import cvt_pkg::*;

    cvt_ctl_t ctl;

    cvt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl)
    );

    cvt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .angle     (angle),
        .row_sel   (row_sel),
        .view_x    (view_x),
        .view_y    (view_y),
        .view_z    (view_z)
    );

endmodule

// File: hw/rtl/cvt_checker.sv
`timescale 1ns / 1ps
// Port-level checks for camera_view_transform, attached by bind.
// Depends on cvt_pkg.
module cvt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [2:0]         cmd,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] view_x
);
    import cvt_pkg::*;

    // a stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(view_x))
        else $error("result changed while stalled");

    // no result appears right after an accept
    a_no_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result too early");

    // a transform keeps the block busy
    a_busy_after_xform: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && cmd == CMD_XFORM |=> !in_ready)
        else $error("accepted item during transform");

endmodule

bind camera_view_transform cvt_checker u_cvt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .view_x    (view_x)
);

// File: sim/camera_view_transform_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for camera_view_transform: directed and random command
// items against a Q16.16/Q2.16 view matrix predictor. Depends on cvt_pkg and the RTL.
module camera_view_transform_test;
    import cvt_pkg::*;

    localparam logic [1:0] REG_NONE = 2'd3;     // unmapped register index
    localparam int          WATCHDOG = 5000;
    localparam longint      QHI = 131071;
    localparam longint      QLO = -131072;
    localparam longint      UNIT = 65536;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } view_t;

    class view_scoreboard;
        longint cam[3];
        longint mtx[9];
        view_t  pending_views[$];
        int     mismatches;
        longint atan_steps[24];

        function void init();
            atan_steps = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                           10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                           83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
            mismatches = 0;
            foreach (cam[i]) cam[i] = 0;
            foreach (mtx[i]) mtx[i] = (i % 4 == 0) ? UNIT : 0;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void write_cam(logic [1:0] addr, logic [31:0] data);
            if (addr != REG_NONE)
                cam[addr] = longint'(signed'(data));
        endfunction

        function void sin_cos(logic [15:0] ang, output longint cs, output longint sn);
            longint x, y, z, dx, dy, c, s;
            x = 652032875;
            y = 0;
            z = longint'(ang[13:0]) << 16;
            for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_steps[i];
                end
                else begin
                    x += dx; y -= dy; z += atan_steps[i];
                end
            end
            c = clamp((x + 8192) >>> 14, QLO, QHI);
            s = clamp((y + 8192) >>> 14, QLO, QHI);
            case (ang[15:14])
                2'd0: begin cs = c;  sn = s;  end
                2'd1: begin cs = -s; sn = c;  end
                2'd2: begin cs = -c; sn = -s; end
                default: begin cs = s; sn = -c; end
            endcase
        endfunction

        function void note_item(logic [2:0] op, logic signed [31:0] px, logic signed [31:0] py,
                                logic signed [31:0] pz, logic [15:0] ang, logic [1:0] row);
            longint d[3], t[9], nm[9], acc, c, s;
            view_t  v;
            if (op == CMD_XFORM) begin
                d[0] = longint'(px) - cam[0];
                d[1] = longint'(py) - cam[1];
                d[2] = longint'(pz) - cam[2];
                for (int r = 0; r < 3; r++) begin
                    acc = mtx[r*3] * d[0] + mtx[r*3+1] * d[1] + mtx[r*3+2] * d[2];
                    acc = clamp((acc + 32768) >>> 16, -64'sd2147483648, 64'sd2147483647);
                    if (r == 0) v.x = acc[31:0];
                    else if (r == 1) v.y = acc[31:0];
                    else v.z = acc[31:0];
                end
                pending_views.push_back(v);
            end
            else if (op == CMD_ROT_X || op == CMD_ROT_Y || op == CMD_ROT_Z) begin
                sin_cos(ang, c, s);
                if (op == CMD_ROT_X)
                    t = '{UNIT, 0, 0, 0, c, -s, 0, s, c};
                else if (op == CMD_ROT_Y)
                    t = '{c, 0, s, 0, UNIT, 0, -s, 0, c};
                else
                    t = '{c, -s, 0, s, c, 0, 0, 0, UNIT};
                for (int r = 0; r < 3; r++)
                    for (int cc = 0; cc < 3; cc++) begin
                        acc = 0;
                        for (int k = 0; k < 3; k++)
                            acc += mtx[r*3+k] * t[k*3+cc];
                        nm[r*3+cc] = clamp((acc + 32768) >>> 16, QLO, QHI);
                    end
                mtx = nm;
            end
            else if (op == CMD_LOAD && row != 2'd3) begin
                mtx[row*3]   = clamp(longint'(px), QLO, QHI);
                mtx[row*3+1] = clamp(longint'(py), QLO, QHI);
                mtx[row*3+2] = clamp(longint'(pz), QLO, QHI);
            end
        endfunction

        function void check_view(logic signed [31:0] x, logic signed [31:0] y,
                                 logic signed [31:0] z);
            view_t e;
            if (pending_views.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %0d %0d %0d", x, y, z);
                return;
            end
            e = pending_views.pop_front();
            if (x !== e.x || y !== e.y || z !== e.z) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: view mismatch exp (%0d %0d %0d) got (%0d %0d %0d)",
                             e.x, e.y, e.z, x, y, z);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_addr = '0;
    logic [31:0]        cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         cmd = '0;
    logic signed [31:0] coord_x = '0;
    logic signed [31:0] coord_y = '0;
    logic signed [31:0] coord_z = '0;
    logic [15:0]        angle = '0;
    logic [1:0]         row_sel = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] view_x;
    logic signed [31:0] view_y;
    logic signed [31:0] view_z;

    view_scoreboard board;
    bit             quiet = 1'b0;
    int             idle_cycles = 0;

    camera_view_transform DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .angle(angle), .row_sel(row_sel),
        .out_valid(out_valid), .out_ready(out_ready),
        .view_x(view_x), .view_y(view_y), .view_z(view_z)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Receiver stalls and result checking
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready)
                board.check_view(view_x, view_y, view_z);
            out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 13);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_item(logic [2:0] op, logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, logic [15:0] a, logic [1:0] r);
        cmd      <= op;
        coord_x  <= x;
        coord_y  <= y;
        coord_z  <= z;
        angle    <= a;
        row_sel  <= r;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_item(op, x, y, z, a, r);
        // Hold valid for back-to-back items, else drop it for a gap
        if (!quiet && $urandom_range(99) < 13) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic write_camera(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        logic [31:0] vals[3];
        vals = '{px, py, pz};
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_views.size() != 0 || !in_ready) @(posedge clk);
        // Rotations finish without a result; let them drain
        repeat (120) @(posedge clk);
        for (int i = 0; i < 3; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= 2'(i);
            cfg_wdata <= vals[i];
            board.write_cam(2'(i), vals[i]);
            @(posedge clk);
        end
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_NONE;
        cfg_wdata <= $urandom;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0FFF_FFFF) - 32'sh0800_0000;
            default: return $urandom_range(0, 32'h00FF_FFFF) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_entry();
        if ($urandom_range(9) == 0)
            return $urandom;
        return $urandom_range(0, 262143) - 131072;
    endfunction

    task automatic random_item();
        int          sel;
        logic [15:0] a;
        sel = $urandom_range(99);
        a = ($urandom_range(9) == 0) ? 16'($urandom_range(3) << 14) : 16'($urandom);
        if (sel < 45)
            send_item(CMD_XFORM, pick_coord(), pick_coord(), pick_coord(), 16'($urandom),
                      2'($urandom));
        else if (sel < 75)
            send_item(3'($urandom_range(CMD_ROT_X, CMD_ROT_Z)), $urandom, $urandom, $urandom,
                      a, 2'($urandom));
        else if (sel < 94)
            send_item(CMD_LOAD, pick_entry(), pick_entry(), pick_entry(), 16'($urandom),
                      2'($urandom_range(9) == 0 ? 3 : $urandom_range(2)));
        else
            send_item(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom,
                      16'($urandom), 2'($urandom));
    endtask

    initial begin
        logic [31:0] cams[7][3];
        board = new();
        board.init();
        cams = '{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h0},
                 '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF},
                 '{32'h0001_0000, 32'hFFFE_8000, 32'h0012_3456},
                 '{32'h0, 32'h0, 32'h0},
                 '{32'hFFF0_0000, 32'h000A_0000, 32'h7FFF_FFFF},
                 '{32'h0, 32'h8000_0000, 32'h8000_0000},
                 '{32'h0005_0000, 32'h0003_0000, 32'hFFFD_0000}};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes on the identity, each rotation at quadrant edges,
        // out-of-range row elements, row select three and unused commands
        send_item(CMD_XFORM, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 16'h0, 2'd0);
        send_item(CMD_XFORM, 32'sh0001_8000, -32'sh0000_8000, 32'shFFFF_FFFF, 16'h0, 2'd0);
        send_item(CMD_ROT_X, 0, 0, 0, 16'h0000, 2'd0);
        send_item(CMD_ROT_Y, 0, 0, 0, 16'h4000, 2'd0);
        send_item(CMD_ROT_Z, 0, 0, 0, 16'h8000, 2'd0);
        send_item(CMD_ROT_X, 0, 0, 0, 16'hC000, 2'd0);
        send_item(CMD_ROT_Y, 0, 0, 0, 16'hFFFF, 2'd0);
        send_item(CMD_ROT_Z, 0, 0, 0, 16'h3FFF, 2'd0);
        send_item(CMD_XFORM, 32'sh0010_0000, 32'sh0020_0000, -32'sh0030_0000, 16'h0, 2'd0);
        send_item(CMD_LOAD, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_FFFF, 16'h0, 2'd0);
        send_item(CMD_LOAD, -32'sh0002_0000, 32'sh0002_0000, 32'sh0, 16'h0, 2'd1);
        send_item(CMD_LOAD, 32'sh0, 32'sh0, 32'sh0001_0000, 16'h0, 2'd2);
        send_item(CMD_LOAD, 32'sh1234, 32'sh5678, 32'sh9ABC, 16'h0, 2'd3);
        send_item(CMD_XFORM, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'h0, 2'd0);
        send_item(CMD_XFORM, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 16'h0, 2'd0);
        send_item(3'd5, $urandom, $urandom, $urandom, 16'hFFFF, 2'd3);
        send_item(3'd6, 0, 0, 0, 16'h0, 2'd0);
        send_item(3'd7, $urandom, $urandom, $urandom, 16'h1234, 2'd1);
        send_item(CMD_XFORM, 32'sh0003_0000, -32'sh0004_0000, 32'sh0005_0000, 16'h0, 2'd0);

        for (int ph = 0; ph < 7; ph++) begin
            write_camera(cams[ph][0], cams[ph][1], cams[ph][2]);
            for (int n = 0; n < 200; n++) begin
                quiet = (ph == 3 && n >= 20 && n < 180);
                random_item();
            end
        end
        quiet = 1'b0;

        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_views.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
